>>> hw/rtl/bole_pkg.sv
`default_nettype none

package bole_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LenW    = 7;
  localparam int unsigned CapW    = 7;

  localparam logic [CapW-1:0] CapResetVal = 7'd64;

  typedef enum logic [ModeW-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_INS_AT    = 3'd2,
    MODE_EXT_FRONT = 3'd3,
    MODE_EXT_BACK  = 3'd4,
    MODE_EXT_AT    = 3'd5,
    MODE_READ_AT   = 3'd6,
    MODE_CLEAR     = 3'd7
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_EXT  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [IndexW-1:0] item_index;
    logic [WordW-1:0]  data_in;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               data_valid;
    logic [WordW-1:0]   data_out;
    logic [LenW-1:0]    length_now;
    logic               is_full;
    logic               is_empty;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/bole_cell.sv
`default_nettype none

// One list position. Insert: positions above the gap take the left
// neighbor, the gap takes the new word. Extract: positions at and above
// the hole take the right neighbor.
module bole_cell #(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                    clk_i,
  input  bole_pkg::cell_op_e     op_i,
  input  wire  [IDX_W-1:0]       pos_i,
  input  wire  [DATA_WIDTH-1:0]  word_i,
  input  wire  [DATA_WIDTH-1:0]  left_i,
  input  wire  [DATA_WIDTH-1:0]  right_i,
  input  wire  [IDX_W-1:0]       rd_pos_i,
  output logic [DATA_WIDTH-1:0]  data_o,
  output logic [DATA_WIDTH-1:0]  rd_data_o
);
  import bole_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (op_i)
      CELL_INS: begin
        if (MyIdx == pos_i) begin
          data_d = word_i;
        end else if (MyIdx > pos_i) begin
          data_d = left_i;
        end
      end
      CELL_EXT: begin
        if (MyIdx >= pos_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  assign rd_data_o = (MyIdx == rd_pos_i) ? data_q : '0;

endmodule

`default_nettype wire

>>> hw/rtl/bounded_ordered_list_engine.sv
`default_nettype none

// Channel  Direction  Handshake                     Payload
// in       input      in_valid_i / in_ready_o       in_data_i  (in_item_t)
// out      output     out_valid_o / out_ready_i     out_data_o (out_item_t)
// cfg      input      cfg_valid_i / cfg_ready_o     cfg_data_i (capacity_limit)
//
// For every item the whole row of cells shifts in parallel on
// the accepting edge and the result lands in the output register.
// A new item is accepted while the held result is taken in the same cycle,
// so the sustained rate is one item per cycle; only a stalled output stops it.
// Reset empties the list and sets the capacity to 64; cell contents are not
// cleared, positions at or above the length are never read.
// The cfg port is always ready.
module bounded_ordered_list_engine #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  bole_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output bole_pkg::out_item_t   out_data_o,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire  [bole_pkg::CapW-1:0] cfg_data_i
);
  import bole_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // compare width wide enough for count, index and capacity
  localparam int unsigned CMP_W = (CNT_W > IndexW) ? CNT_W : IndexW;

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] count_d, count_q;
  logic [CapW-1:0]  cap_q;
  logic             out_valid_q;
  out_item_t        out_d, out_q;

  logic fire;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0]      cnt_x, idx_x, cap_x, last_x;
  logic [CMP_W-1:0]      ins_pos_x, ext_pos_x, rd_pos_x;
  logic                  is_ins, is_ext, is_read, is_clear;
  logic                  ins_refused, ext_bad, rd_bad;
  cell_op_e              cell_op;
  logic [IDX_W-1:0]      pos_sh, pos_rd;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] rd_data;

  assign cnt_x  = CMP_W'(count_q);
  assign idx_x  = CMP_W'(in_data_i.item_index);
  assign cap_x  = CMP_W'(cap_q);
  assign last_x = cnt_x - CMP_W'(1);
  assign word   = DATA_WIDTH'(in_data_i.data_in);

  assign is_ins   = (in_data_i.mode == MODE_INS_FRONT) || (in_data_i.mode == MODE_INS_BACK) ||
                    (in_data_i.mode == MODE_INS_AT);
  assign is_ext   = (in_data_i.mode == MODE_EXT_FRONT) || (in_data_i.mode == MODE_EXT_BACK) ||
                    (in_data_i.mode == MODE_EXT_AT);
  assign is_read  = (in_data_i.mode == MODE_READ_AT);
  assign is_clear = (in_data_i.mode == MODE_CLEAR);

  // capacity saturates at DEPTH: count >= min(cap, DEPTH)
  assign ins_refused = (cnt_x >= cap_x) || (count_q == CNT_W'(DEPTH));

  always_comb begin
    if (in_data_i.mode == MODE_INS_FRONT) begin
      ins_pos_x = '0;
    end else if ((in_data_i.mode == MODE_INS_BACK) || (idx_x > cnt_x)) begin
      ins_pos_x = cnt_x;
    end else begin
      ins_pos_x = idx_x;
    end

    if (in_data_i.mode == MODE_EXT_FRONT) begin
      ext_pos_x = '0;
    end else if (in_data_i.mode == MODE_EXT_BACK) begin
      ext_pos_x = last_x;
    end else begin
      ext_pos_x = idx_x;
    end

    // read past the back returns the back element
    rd_pos_x = (idx_x >= cnt_x) ? last_x : idx_x;
  end

  assign ext_bad = (count_q == '0) || (ext_pos_x >= cnt_x);
  assign rd_bad  = (count_q == '0);

  always_comb begin
    cell_op = CELL_HOLD;
    if (fire && is_ins && !ins_refused) begin
      cell_op = CELL_INS;
    end else if (fire && is_ext && !ext_bad) begin
      cell_op = CELL_EXT;
    end
  end

  assign pos_sh = is_ins ? IDX_W'(ins_pos_x) : IDX_W'(ext_pos_x);
  assign pos_rd = is_read ? IDX_W'(rd_pos_x) : IDX_W'(ext_pos_x);

  // ---------------------------------------------------------------------
  // Row of cells
  // ---------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    bole_cell #(
      .INDEX      (g),
      .IDX_W      (IDX_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (cell_op),
      .pos_i     (pos_sh),
      .word_i    (word),
      .left_i    (left_w),
      .right_i   (right_w),
      .rd_pos_i  (pos_rd),
      .data_o    (cell_data[g]),
      .rd_data_o (cell_rd[g])
    );
  end

  // only the selected cell drives nonzero data
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

  // ---------------------------------------------------------------------
  // Result
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0] cnt_d_x;

  always_comb begin
    count_d          = count_q;
    out_d.status     = ST_OK;
    out_d.data_valid = 1'b0;
    out_d.data_out   = '0;
    if (is_ins) begin
      if (ins_refused) begin
        out_d.status = ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (is_ext) begin
      if (ext_bad) begin
        out_d.status = ST_RANGE;
      end else begin
        count_d          = count_q - CNT_W'(1);
        out_d.data_valid = 1'b1;
        out_d.data_out   = WordW'(rd_data);
      end
    end else if (is_read) begin
      if (rd_bad) begin
        out_d.status = ST_RANGE;
      end else begin
        out_d.data_valid = 1'b1;
        out_d.data_out   = WordW'(rd_data);
      end
    end else if (is_clear) begin
      count_d = '0;
    end
    cnt_d_x          = CMP_W'(count_d);
    out_d.length_now = LenW'(count_d);
    out_d.is_empty   = (count_d == '0);
    out_d.is_full    = (count_d != '0) &&
                       ((cnt_d_x >= cap_x) || (count_d == CNT_W'(DEPTH)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CapResetVal;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list length above depth");

  a_ins_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_ins && !ins_refused) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("accepted insert did not grow the list");

  a_full_refused : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_ins && ins_refused) |=>
      (out_q.status == ST_FULL) && (count_q == $past(count_q)))
    else $error("refused insert changed the list or status");

  a_data_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.data_valid ? (out_q.status == ST_OK) : (out_q.data_out == '0)))
    else $error("result data inconsistent with status");

endmodule

`default_nettype wire

>>> tb/sv/bounded_ordered_list_engine_tb.sv
`timescale 1ns / 100ps

module bounded_ordered_list_engine_tb;
  import bole_pkg::*;

  localparam int unsigned       ListDepth  = 64;
  localparam logic [IndexW-1:0] MaxIndex   = '1;
  localparam int unsigned       CycleLimit = 400000;
  localparam int unsigned       NumPhases  = 10;
  localparam int unsigned       PhaseItems = 110;

  // One row of the directed table: either a capacity write or an op with
  // its result typed in by hand.
  typedef struct {
    bit              is_cfg;
    logic [CapW-1:0] cap;
    in_item_t        op;
    out_item_t       want;
  } dir_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  in_item_t        in_data_i;
  logic            out_valid_o;
  logic            out_ready_i;
  out_item_t       out_data_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [CapW-1:0] cfg_data_i;

  // Tags that ride along with the item on the input channel: when set, the
  // hand-typed result replaces the predicted one.
  logic      op_typed;
  out_item_t op_want;

  // Shadow copy of the list, its length and the capacity register.
  logic [WordW-1:0] shadow_words [ListDepth];
  int unsigned      shadow_len;
  int unsigned      shadow_cap;

  out_item_t   awaited_results [$];
  dir_row_t    directed_rows [$];
  out_item_t   head_want;
  out_item_t   fresh_want;
  int unsigned errors;
  int unsigned cycles;

  // Per-phase capacity and share of inserts (percent) for the random part.
  // Phase 2 drops the capacity far below a well-filled list; phase 3 is
  // capacity zero; 127 checks saturation at the built depth.
  int unsigned phase_cap [NumPhases] = '{64, 127, 3, 0, 64, 1, 20, 40, 127, 2};
  int unsigned phase_ins [NumPhases] = '{80, 70, 30, 50, 75, 50, 50, 40, 85, 25};

  bounded_ordered_list_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Applies one op to the shadow list and returns the result it should give.
  function automatic out_item_t predict_list_op(in_item_t it);
    out_item_t   res;
    int unsigned eff_cap;
    int unsigned pos;
    int unsigned idx;
    int unsigned i;
    res = '0;
    res.status = ST_OK;
    idx = 32'(it.item_index);
    eff_cap = (shadow_cap > ListDepth) ? ListDepth : shadow_cap;
    case (mode_e'(it.mode))
      MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
        if (shadow_len >= eff_cap || shadow_len >= ListDepth) begin
          res.status = ST_FULL;
        end else begin
          // an index past the end appends
          if (it.mode == MODE_INS_FRONT) pos = 0;
          else if (it.mode == MODE_INS_BACK || idx > shadow_len) pos = shadow_len;
          else pos = idx;
          for (i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i - 1];
          shadow_words[pos] = it.data_in;
          shadow_len++;
        end
      end
      MODE_EXT_FRONT, MODE_EXT_BACK, MODE_EXT_AT: begin
        if (shadow_len == 0) begin
          res.status = ST_RANGE;
        end else begin
          if (it.mode == MODE_EXT_FRONT) pos = 0;
          else if (it.mode == MODE_EXT_BACK) pos = shadow_len - 1;
          else pos = idx;
          if (pos >= shadow_len) begin
            res.status = ST_RANGE;
          end else begin
            res.data_valid = 1'b1;
            res.data_out = shadow_words[pos];
            for (i = pos; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i + 1];
            shadow_len--;
          end
        end
      end
      MODE_READ_AT: begin
        // past the end reads the back element
        if (shadow_len == 0) begin
          res.status = ST_RANGE;
        end else begin
          pos = (idx >= shadow_len) ? shadow_len - 1 : idx;
          res.data_valid = 1'b1;
          res.data_out = shadow_words[pos];
        end
      end
      default: begin
        shadow_len = 0;
      end
    endcase
    res.length_now = LenW'(shadow_len);
    res.is_full = (shadow_len != 0) && (shadow_len >= eff_cap);
    res.is_empty = (shadow_len == 0);
    return res;
  endfunction

  function automatic void check_field(string name, logic [WordW-1:0] want,
                                      logic [WordW-1:0] got);
    if (want !== got) begin
      $display("%0t %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Random op; the index mostly lands in or just past the list, sometimes
  // anywhere in its range.
  function automatic in_item_t random_op(int unsigned ins_pct);
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) it.mode = MODE_CLEAR;
    else if (r < 2 + ins_pct) it.mode = ModeW'($urandom_range(MODE_INS_FRONT, MODE_INS_AT));
    else it.mode = ModeW'($urandom_range(MODE_EXT_FRONT, MODE_READ_AT));
    if ($urandom_range(0, 3) == 0) it.item_index = IndexW'($urandom_range(0, MaxIndex));
    else it.item_index = IndexW'($urandom_range(0, shadow_len + 1));
    it.data_in = $urandom();
    return it;
  endfunction

  function automatic void add_op(mode_e mode, logic [IndexW-1:0] idx,
                                 logic [WordW-1:0] word, status_e st, logic vld,
                                 logic [WordW-1:0] dout, logic [LenW-1:0] len,
                                 logic full, logic empty);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cap = '0;
    row.op.mode = mode;
    row.op.item_index = idx;
    row.op.data_in = word;
    row.want.status = st;
    row.want.data_valid = vld;
    row.want.data_out = dout;
    row.want.length_now = len;
    row.want.is_full = full;
    row.want.is_empty = empty;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CapW-1:0] cap);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.cap = cap;
    row.op = '0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic send_op(in_item_t it, bit typed, out_item_t want);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    op_typed <= typed;
    op_want <= want;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task automatic idle_gap(int unsigned n);
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Capacity writes only once the block has drained: no item in flight.
  task automatic write_capacity(logic [CapW-1:0] cap);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cap;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Handshakes are sampled at the falling edge: everything then is stable
  // and matches what the next rising edge will see. Results are checked
  // before the new item's expectation is queued.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t result expected none got %h", $time, out_data_o);
          errors++;
        end else begin
          head_want = awaited_results.pop_front();
          check_field("status", WordW'(head_want.status), WordW'(out_data_o.status));
          check_field("data_valid", WordW'(head_want.data_valid),
                      WordW'(out_data_o.data_valid));
          check_field("data_out", head_want.data_out, out_data_o.data_out);
          check_field("length_now", WordW'(head_want.length_now),
                      WordW'(out_data_o.length_now));
          check_field("is_full", WordW'(head_want.is_full), WordW'(out_data_o.is_full));
          check_field("is_empty", WordW'(head_want.is_empty), WordW'(out_data_o.is_empty));
        end
      end
      if (cfg_valid_i && cfg_ready_o) shadow_cap = 32'(cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        fresh_want = predict_list_op(in_data_i);
        awaited_results.push_back(op_typed ? op_want : fresh_want);
      end
    end
  end

  // Receiver: ready runs of random length, now and then a long one with no
  // stall at all, separated by stalls of mostly short length.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_ready_i <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20))
        @(posedge clk_i);
      out_ready_i <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    op_typed = 1'b0;
    op_want = '0;
    shadow_len = 0;
    shadow_cap = 32'(CapResetVal);
    errors = 0;
    cycles = 0;
    phase_cap[6] = $urandom_range(1, 64);
    phase_cap[9] = $urandom_range(2, 63);

    // Empty list: every extract and read is out of range.
    add_op(MODE_EXT_FRONT, 0, 32'hDEADBEEF, ST_RANGE, 0, 0, 0, 0, 1);
    add_op(MODE_READ_AT, MaxIndex, 0, ST_RANGE, 0, 0, 0, 0, 1);
    add_op(MODE_EXT_AT, 0, 0, ST_RANGE, 0, 0, 0, 0, 1);
    // Build 5A5A5A5A FFFFFFFF 12345678 00000000 A5A5A5A5; the far index appends.
    add_op(MODE_INS_FRONT, 0, 32'hFFFFFFFF, ST_OK, 0, 0, 1, 0, 0);
    add_op(MODE_INS_BACK, 0, 32'h00000000, ST_OK, 0, 0, 2, 0, 0);
    add_op(MODE_INS_AT, MaxIndex, 32'hA5A5A5A5, ST_OK, 0, 0, 3, 0, 0);
    add_op(MODE_INS_AT, 0, 32'h5A5A5A5A, ST_OK, 0, 0, 4, 0, 0);
    add_op(MODE_INS_AT, 2, 32'h12345678, ST_OK, 0, 0, 5, 0, 0);
    // Read past the end gives the back element.
    add_op(MODE_READ_AT, MaxIndex, 0, ST_OK, 1, 32'hA5A5A5A5, 5, 0, 0);
    add_op(MODE_READ_AT, 0, 0, ST_OK, 1, 32'h5A5A5A5A, 5, 0, 0);
    add_op(MODE_EXT_AT, 5, 0, ST_RANGE, 0, 0, 5, 0, 0);
    // Extract at index zero takes the front.
    add_op(MODE_EXT_AT, 0, 0, ST_OK, 1, 32'h5A5A5A5A, 4, 0, 0);
    add_op(MODE_EXT_BACK, 0, 0, ST_OK, 1, 32'hA5A5A5A5, 3, 0, 0);
    add_op(MODE_EXT_AT, 1, 0, ST_OK, 1, 32'h12345678, 2, 0, 0);
    add_op(MODE_EXT_FRONT, 0, 0, ST_OK, 1, 32'hFFFFFFFF, 1, 0, 0);
    add_op(MODE_CLEAR, 0, 0, ST_OK, 0, 0, 0, 0, 1);
    add_op(MODE_EXT_BACK, 0, 0, ST_RANGE, 0, 0, 0, 0, 1);
    // Capacity one fills after a single insert.
    add_cfg(1);
    add_op(MODE_INS_BACK, 0, 32'h00000001, ST_OK, 0, 0, 1, 1, 0);
    add_op(MODE_INS_FRONT, 0, 32'h00000002, ST_FULL, 0, 0, 1, 1, 0);
    // Capacity zero below the current length: nothing dropped, all inserts refused.
    add_cfg(0);
    add_op(MODE_INS_AT, 0, 32'h00000003, ST_FULL, 0, 0, 1, 1, 0);
    add_op(MODE_EXT_FRONT, 0, 0, ST_OK, 1, 32'h00000001, 0, 0, 1);
    add_op(MODE_INS_BACK, 0, 32'h00000004, ST_FULL, 0, 0, 0, 0, 1);
    // Above the depth saturates.
    add_cfg(MaxIndex);
    add_op(MODE_INS_AT, 0, 32'hFFFF0000, ST_OK, 0, 0, 1, 0, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        write_capacity(directed_rows[r].cap);
      end else begin
        idle_gap(pick_gap());
        send_op(directed_rows[r].op, 1'b1, directed_rows[r].want);
      end
    end

    // Random phases; the list carries over between them, so a lowered
    // capacity often lands below the current length. Phases 2 and 7 send
    // back to back.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_capacity(CapW'(phase_cap[p]));
      repeat (PhaseItems) begin
        if (p != 2 && p != 7) idle_gap(pick_gap());
        send_op(random_op(phase_ins[p]), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
